@@ design/byte_ring_buffer_burst_top_defines.svh @@
// Assertion macros for the byte ring buffer top level.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef BYTE_RING_BUFFER_BURST_TOP_DEFINES_SVH
`define BYTE_RING_BUFFER_BURST_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BRB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("brb: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("brb: next-cycle check failed");

`endif

@@ design/brb_pkg.sv @@
// Shared constants, command codes and control structs for the byte ring buffer.
// No dependencies; used by brb_seq, brb_merge and the top level.
package brb_pkg;

  localparam int LANES  = 8;
  localparam int LANE_W = 3;
  localparam int BYTE_W = 8;
  localparam int DATA_W = 64;
  localparam int LEN_W  = 7;
  localparam int FILL_W = 10;
  localparam int CMD_W  = 2;
  localparam int LOG_W  = 4;

  localparam int DEF_RING_DEPTH = 1024;
  localparam int DEF_MAX_WRITE  = 8;
  localparam int DEF_MAX_READ   = 64;

  localparam logic [LOG_W-1:0] SIZE_LOG2_RESET = 4'd10;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Per-lane strobes from the sequencer to the memory banks.
  typedef struct packed {
    logic [LANES-1:0] wr_en;
    logic [LANES-1:0] rd_en;
  } lane_ctrl_t;

  // One result as issued by the sequencer to the merge stage.
  typedef struct packed {
    logic              byte_valid;
    logic [LANE_W-1:0] sel;
    logic [LEN_W-1:0]  done_count;
    logic [FILL_W-1:0] fill_level;
    logic              last;
  } res_t;

endpackage

@@ design/brb_lane.sv @@
// One byte-wide memory bank of the ring; holds every eighth ring address.
// Depends on nothing but its ROW_W parameter.
module brb_lane #(
  parameter int ROW_W = 7
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [ROW_W-1:0] wr_row,
  input  logic [7:0]       wr_data,
  input  logic             rd_en,
  input  logic [ROW_W-1:0] rd_row,
  output logic [7:0]       rd_data
);

  logic [7:0] mem [2**ROW_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
  end

  // Read data stays put until the next read of this bank.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

endmodule

@@ design/brb_merge.sv @@
// Merge stage: picks the read bank's byte and holds results in the output register.
// Depends on brb_pkg.
module brb_merge (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                issue,
  input  brb_pkg::res_t                       issue_res,
  input  logic [brb_pkg::BYTE_W-1:0]          bank_q [brb_pkg::LANES],
  output logic                                can_issue,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [brb_pkg::BYTE_W-1:0]          read_byte,
  output logic                                byte_valid,
  output logic [brb_pkg::LEN_W-1:0]           done_count,
  output logic [brb_pkg::FILL_W-1:0]          fill_level,
  output logic                                last
);

  logic          pend;
  brb_pkg::res_t pend_res;
  logic          move;

  // The pending stage lines up with the bank read latency.
  assign move      = pend && (!out_valid || !out_stall);
  assign can_issue = !pend || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= issue || (pend && !move);
      if (move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_res <= issue_res;
    end
    if (move) begin
      read_byte  <= pend_res.byte_valid ? bank_q[pend_res.sel] : '0;
      byte_valid <= pend_res.byte_valid;
      done_count <= pend_res.done_count;
      fill_level <= pend_res.fill_level;
      last       <= pend_res.last;
    end
  end

endmodule

@@ design/brb_seq.sv @@
// Sequencer: ring pointers, size register, item holding register and lane strobes.
// Depends on brb_pkg.
module brb_seq #(
  parameter int RING_DEPTH = brb_pkg::DEF_RING_DEPTH,
  parameter int MAX_WRITE  = brb_pkg::DEF_MAX_WRITE,
  parameter int MAX_READ   = brb_pkg::DEF_MAX_READ,
  parameter int ROW_W      = 7
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [brb_pkg::CMD_W-1:0]         cmd,
  input  logic [brb_pkg::DATA_W-1:0]        write_bytes,
  input  logic [brb_pkg::LEN_W-1:0]         burst_length,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [brb_pkg::LOG_W-1:0]         size_log2,
  input  logic                              can_issue,
  output logic                              issue,
  output brb_pkg::res_t                     issue_res,
  output brb_pkg::lane_ctrl_t               lane_ctrl,
  output logic [ROW_W-1:0]                  wr_row [brb_pkg::LANES],
  output logic [brb_pkg::BYTE_W-1:0]        wr_data [brb_pkg::LANES],
  output logic [ROW_W-1:0]                  rd_row
);

  localparam int AW = $clog2(RING_DEPTH + 1) - 1;
  localparam int EW = AW + 3;
  localparam int CW = (AW > 7) ? AW : 7;
  localparam int LW = brb_pkg::LEN_W;
  localparam int FW = brb_pkg::FILL_W;
  localparam logic [3:0]    AW_L        = 4'((AW < 15) ? AW : 15);
  localparam logic [LW-1:0] MAX_WRITE_L = LW'(MAX_WRITE);
  localparam logic [LW-1:0] MAX_READ_L  = LW'(MAX_READ);

  logic [AW-1:0]                   rp;
  logic [AW-1:0]                   wp;
  logic [brb_pkg::LOG_W-1:0]       lg;
  logic                            hold;
  logic [brb_pkg::CMD_W-1:0]       h_cmd;
  logic [brb_pkg::DATA_W-1:0]      h_data;
  logic [LW-1:0]                   h_len;
  logic                            reading;
  logic [AW-1:0]                   rd_addr;
  logic [LW-1:0]                   rd_left;
  logic [LW-1:0]                   rd_n;
  logic [AW-1:0]                   rd_after;

  logic [3:0]    lg_eff;
  logic [AW-1:0] mask;
  logic [AW-1:0] fill;
  logic [AW-1:0] room;
  logic [LW-1:0] len_c;
  logic [LW-1:0] n_new;
  logic          wr_ok;
  logic [AW-1:0] wp_add;
  logic          do_item;
  logic          do_read;
  logic [EW-1:0] wp_ext;
  logic [EW-1:0] mask_ext;
  logic [EW-1:0] rd_ext;
  logic [2:0]    rd_lane;

  assign in_stall  = hold;
  assign cfg_ready = 1'b1;

  assign lg_eff = (lg > AW_L) ? AW_L : lg;
  assign mask   = ~({AW{1'b1}} << lg_eff);
  assign fill   = (wp - rp) & mask;
  assign room   = mask - fill;
  assign len_c  = (h_len > MAX_READ_L) ? MAX_READ_L : h_len;
  assign n_new  = (CW'(len_c) > CW'(fill)) ? LW'(fill) : len_c;
  assign wr_ok  = (h_len <= MAX_WRITE_L) && (CW'(h_len) <= CW'(room));
  assign wp_add = (wp + AW'(h_len)) & mask;

  assign do_item = hold && !reading && can_issue;
  assign do_read = reading && can_issue;

  assign wp_ext   = EW'(wp);
  assign mask_ext = EW'(mask);

  // Each lane owns the ring addresses whose low three bits equal its number,
  // so a burst of up to eight bytes lands on distinct lanes.
  for (genvar l = 0; l < brb_pkg::LANES; l++) begin : g_wr
    logic [2:0]    off;
    logic          in_ring;
    logic [AW-1:0] addr;
    logic [EW-1:0] addr_ext;

    assign off      = (3'(l) - wp_ext[2:0]) & mask_ext[2:0];
    assign in_ring  = (3'(l) & ~mask_ext[2:0]) == 3'd0;
    assign addr     = (wp + AW'(off)) & mask;
    assign addr_ext = EW'(addr);
    assign lane_ctrl.wr_en[l] = do_item && (h_cmd == brb_pkg::CMD_WRITE) && wr_ok &&
                                in_ring && ({4'd0, off} < h_len);
    assign wr_row[l]  = addr_ext[ROW_W+2:3];
    assign wr_data[l] = h_data[{off, 3'b000} +: 8];
  end

  assign rd_ext  = EW'(rd_addr);
  assign rd_lane = rd_ext[2:0];
  assign rd_row  = rd_ext[ROW_W+2:3];
  assign lane_ctrl.rd_en = do_read ? (brb_pkg::LANES'(1) << rd_lane) : '0;

  // A read that finds bytes starts the byte loop and issues nothing itself.
  assign issue = do_read ||
                 (do_item && !((h_cmd == brb_pkg::CMD_READ) && (n_new != '0)));

  always_comb begin
    issue_res            = '0;
    issue_res.last       = 1'b1;
    issue_res.fill_level = FW'(fill);
    if (reading) begin
      issue_res.byte_valid = 1'b1;
      issue_res.sel        = rd_lane;
      issue_res.done_count = rd_n;
      issue_res.fill_level = FW'(rd_after);
      issue_res.last       = (rd_left == LW'(1));
    end else begin
      case (h_cmd)
        brb_pkg::CMD_WRITE: begin
          if (wr_ok) begin
            issue_res.done_count = h_len;
            issue_res.fill_level = FW'((wp_add - rp) & mask);
          end
        end
        brb_pkg::CMD_CLEAR: begin
          issue_res.fill_level = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp       <= '0;
      wp       <= '0;
      lg       <= brb_pkg::SIZE_LOG2_RESET;
      hold     <= 1'b0;
      reading  <= 1'b0;
      rd_addr  <= '0;
      rd_left  <= '0;
      rd_n     <= '0;
      rd_after <= '0;
    end else begin
      if (in_valid && !hold) begin
        hold <= 1'b1;
      end
      if (do_item) begin
        hold <= 1'b0;
        case (h_cmd)
          brb_pkg::CMD_WRITE: begin
            if (wr_ok) begin
              wp <= wp_add;
            end
          end
          brb_pkg::CMD_READ: begin
            if (n_new != '0) begin
              reading  <= 1'b1;
              rd_addr  <= rp;
              rd_left  <= n_new;
              rd_n     <= n_new;
              rd_after <= fill - AW'(n_new);
              rp       <= (rp + AW'(n_new)) & mask;
            end
          end
          brb_pkg::CMD_CLEAR: begin
            rp <= '0;
            wp <= '0;
          end
          default: begin
          end
        endcase
      end
      if (do_read) begin
        rd_addr <= (rd_addr + AW'(1)) & mask;
        rd_left <= rd_left - LW'(1);
        if (rd_left == LW'(1)) begin
          reading <= 1'b0;
        end
      end
      if (cfg_valid) begin
        lg <= size_log2;
        rp <= '0;
        wp <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !hold) begin
      h_cmd  <= cmd;
      h_data <= write_bytes;
      h_len  <= burst_length;
    end
  end

endmodule

@@ design/byte_ring_buffer_burst_top.sv @@
// Byte ring buffer FIFO with burst writes of up to eight bytes and burst reads.
// Results pass the holding register, the pending stage and the output register; a read that
// finds bytes first enters its read state, then issues them through the banks one per cycle
// while the output does not stall. No item is taken while one is held, and a held item waits
// until a read has issued its last byte. Reset (synchronous) zeroes both pointers, sets
// size_log2 to 10 and leaves the store undefined. Depends on brb_pkg, brb_seq, brb_lane, brb_merge.
`include "byte_ring_buffer_burst_top_defines.svh"

module byte_ring_buffer_burst_top #(
  parameter int RING_DEPTH = brb_pkg::DEF_RING_DEPTH,
  parameter int MAX_WRITE  = brb_pkg::DEF_MAX_WRITE,
  parameter int MAX_READ   = brb_pkg::DEF_MAX_READ
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [brb_pkg::CMD_W-1:0]   cmd,
  input  logic [brb_pkg::DATA_W-1:0]  write_bytes,
  input  logic [brb_pkg::LEN_W-1:0]   burst_length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [brb_pkg::BYTE_W-1:0]  read_byte,
  output logic                        byte_valid,
  output logic [brb_pkg::LEN_W-1:0]   done_count,
  output logic [brb_pkg::FILL_W-1:0]  fill_level,
  output logic                        last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [brb_pkg::LOG_W-1:0]   size_log2
);

  localparam int AW    = $clog2(RING_DEPTH + 1) - 1;
  localparam int ROW_W = (AW > 3) ? AW - 3 : 1;

  logic                       can_issue;
  logic                       issue;
  brb_pkg::res_t              issue_res;
  brb_pkg::lane_ctrl_t        lane_ctrl;
  logic [ROW_W-1:0]           wr_row [brb_pkg::LANES];
  logic [brb_pkg::BYTE_W-1:0] wr_data [brb_pkg::LANES];
  logic [ROW_W-1:0]           rd_row;
  logic [brb_pkg::BYTE_W-1:0] bank_q [brb_pkg::LANES];

  brb_seq #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_WRITE  (MAX_WRITE),
    .MAX_READ   (MAX_READ),
    .ROW_W      (ROW_W)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .write_bytes  (write_bytes),
    .burst_length (burst_length),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .size_log2    (size_log2),
    .can_issue    (can_issue),
    .issue        (issue),
    .issue_res    (issue_res),
    .lane_ctrl    (lane_ctrl),
    .wr_row       (wr_row),
    .wr_data      (wr_data),
    .rd_row       (rd_row)
  );

  for (genvar g = 0; g < brb_pkg::LANES; g++) begin : g_lane
    brb_lane #(
      .ROW_W (ROW_W)
    ) u_lane (
      .clk     (clk),
      .wr_en   (lane_ctrl.wr_en[g]),
      .wr_row  (wr_row[g]),
      .wr_data (wr_data[g]),
      .rd_en   (lane_ctrl.rd_en[g]),
      .rd_row  (rd_row),
      .rd_data (bank_q[g])
    );
  end

  brb_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .issue      (issue),
    .issue_res  (issue_res),
    .bank_q     (bank_q),
    .can_issue  (can_issue),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_byte  (read_byte),
    .byte_valid (byte_valid),
    .done_count (done_count),
    .fill_level (fill_level),
    .last       (last)
  );

  // A result without a byte always closes its item and carries a zero byte.
  `BRB_ASSERT_SAME(a_empty_shape, out_valid && !byte_valid, last && (read_byte == 8'd0))
  // A byte transfer always reports a nonzero delivered count.
  `BRB_ASSERT_SAME(a_byte_count, out_valid && byte_valid, done_count != 7'd0)
  `BRB_ASSERT_SAME(a_one_rd_lane, 1'b1, $onehot0(lane_ctrl.rd_en))
  `BRB_ASSERT_SAME(a_rd_wr_apart, |lane_ctrl.wr_en, lane_ctrl.rd_en == '0)
  // Every bank read goes with a byte result issued to the merge stage.
  `BRB_ASSERT_SAME(a_read_lane_hit, |lane_ctrl.rd_en, issue && issue_res.byte_valid)

endmodule

@@ dv/tb_byte_ring_buffer_burst_top.sv @@
// Self-checking testbench for byte_ring_buffer_burst_top: directed and random write,
// read, clear and ring-size traffic, checked result by result against a predictor.
// Depends on brb_pkg and the byte_ring_buffer_burst_top RTL.
module tb_byte_ring_buffer_burst_top;

  localparam int RING_LOG2 = $clog2(brb_pkg::DEF_RING_DEPTH);
  localparam logic [brb_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [brb_pkg::BYTE_W-1:0] rd_byte;
    logic                       rd_valid;
    logic [brb_pkg::LEN_W-1:0]  count;
    logic [brb_pkg::FILL_W-1:0] fill;
    logic                       is_last;
  } fifo_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [brb_pkg::CMD_W-1:0]  cmd = brb_pkg::CMD_WRITE;
  logic [brb_pkg::DATA_W-1:0] write_bytes = '0;
  logic [brb_pkg::LEN_W-1:0]  burst_length = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [brb_pkg::BYTE_W-1:0] read_byte;
  logic                       byte_valid;
  logic [brb_pkg::LEN_W-1:0]  done_count;
  logic [brb_pkg::FILL_W-1:0] fill_level;
  logic                       last;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [brb_pkg::LOG_W-1:0]  size_log2 = brb_pkg::SIZE_LOG2_RESET;

  // Predictor state: the ring contents, both pointers and the ring size in use.
  logic [brb_pkg::BYTE_W-1:0] ring_bytes [brb_pkg::DEF_RING_DEPTH];
  int unsigned       head_ptr = 0;
  int unsigned       tail_ptr = 0;
  int unsigned       ring_log2 = 32'(brb_pkg::SIZE_LOG2_RESET);
  fifo_result_t      expected_results [$];

  int mismatches = 0;
  int results_seen = 0;
  bit sender_active = 1'b0;
  bit source_idle_on = 1'b0;
  bit sink_stall_on = 1'b0;
  int stall_left = 0;
  int quiet_left = 0;

  byte_ring_buffer_burst_top uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .write_bytes  (write_bytes),
    .burst_length (burst_length),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_byte    (read_byte),
    .byte_valid   (byte_valid),
    .done_count   (done_count),
    .fill_level   (fill_level),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .size_log2    (size_log2)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string fname, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("Mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
             fname, results_seen, got, want);
    mismatches++;
  endtask

  function automatic void expect_result(input logic [brb_pkg::BYTE_W-1:0] rd_byte,
                                        input logic rd_valid,
                                        input int unsigned count, input int unsigned fill,
                                        input logic is_last);
    fifo_result_t r;
    r.rd_byte  = rd_byte;
    r.rd_valid = rd_valid;
    r.count    = brb_pkg::LEN_W'(count);
    r.fill     = brb_pkg::FILL_W'(fill);
    r.is_last  = is_last;
    expected_results.push_back(r);
  endfunction

  // Works out the results of one accepted item and updates the ring state.
  function automatic void predict_ring_results(input logic [brb_pkg::CMD_W-1:0] op,
                                               input logic [brb_pkg::DATA_W-1:0] data,
                                               input logic [brb_pkg::LEN_W-1:0] len);
    int unsigned eff_log2, mask, rp, wp, fill, room, n, done, i, len_u;
    len_u = 32'(len);
    eff_log2 = (ring_log2 > RING_LOG2) ? RING_LOG2 : ring_log2;
    mask = (1 << eff_log2) - 1;
    rp = head_ptr & mask;
    wp = tail_ptr & mask;
    fill = (wp - rp) & mask;
    room = mask - fill;
    case (op)
      brb_pkg::CMD_WRITE: begin
        done = 0;
        // All or nothing: a burst that does not fit is dropped whole.
        if (len_u <= brb_pkg::DEF_MAX_WRITE && len_u <= room) begin
          for (i = 0; i < len_u; i++)
            ring_bytes[RING_LOG2'((wp + i) & mask)] = data[8*i +: 8];
          wp = (wp + len_u) & mask;
          fill = (wp - rp) & mask;
          done = len_u;
        end
        head_ptr = rp;
        tail_ptr = wp;
        expect_result('0, 1'b0, done, fill, 1'b1);
      end
      brb_pkg::CMD_READ: begin
        n = (len_u > brb_pkg::DEF_MAX_READ) ? brb_pkg::DEF_MAX_READ : len_u;
        if (n > fill) n = fill;
        if (n == 0) begin
          expect_result('0, 1'b0, 0, fill, 1'b1);
        end else begin
          for (i = 0; i < n; i++)
            expect_result(ring_bytes[RING_LOG2'((rp + i) & mask)], 1'b1, n, fill - n,
                          i + 1 == n);
          head_ptr = (rp + n) & mask;
          tail_ptr = wp;
        end
      end
      brb_pkg::CMD_CLEAR: begin
        head_ptr = 0;
        tail_ptr = 0;
        expect_result('0, 1'b0, 0, 0, 1'b1);
      end
      default: expect_result('0, 1'b0, 0, fill, 1'b1);
    endcase
  endfunction

  always @(posedge clk) begin : check_results
    fifo_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 64'({read_byte, done_count, fill_level}), 64'd0);
      end else begin
        want = expected_results.pop_front();
        if (read_byte !== want.rd_byte)
          report_mismatch("read_byte", 64'(read_byte), 64'(want.rd_byte));
        if (byte_valid !== want.rd_valid)
          report_mismatch("byte_valid", 64'(byte_valid), 64'(want.rd_valid));
        if (done_count !== want.count)
          report_mismatch("done_count", 64'(done_count), 64'(want.count));
        if (fill_level !== want.fill)
          report_mismatch("fill_level", 64'(fill_level), 64'(want.fill));
        if (last !== want.is_last)
          report_mismatch("last", 64'(last), 64'(want.is_last));
      end
    end
  end

  // Output back-pressure: random stall bursts with quiet stretches in between.
  always @(posedge clk) begin
    if (rst || !sink_stall_on) begin
      out_stall <= 1'b0;
      stall_left = 0;
      quiet_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (quiet_left > 0) begin
      out_stall <= 1'b0;
      quiet_left--;
    end else begin
      case ($urandom_range(0, 9))
        0, 1: begin
          stall_left = $urandom_range(0, 11);
          out_stall <= 1'b1;
        end
        2: begin
          quiet_left = $urandom_range(10, 40);
          out_stall <= 1'b0;
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  function automatic logic [brb_pkg::DATA_W-1:0] rand_bytes();
    return {$urandom, $urandom};
  endfunction

  // Must be called right after a rising edge; returns at the edge of the transfer.
  // A valid that stays high for the next item is not touched again here.
  task automatic send_item(input logic [brb_pkg::CMD_W-1:0] op,
                           input logic [brb_pkg::DATA_W-1:0] data,
                           input logic [brb_pkg::LEN_W-1:0] len);
    int gap;
    if (source_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      if (sender_active) in_valid <= 1'b0;
      sender_active = 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd          <= op;
    write_bytes  <= data;
    burst_length <= len;
    in_valid     <= 1'b1;
    sender_active = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_ring_results(op, data, len);
  endtask

  task automatic drain_results();
    if (sender_active) in_valid <= 1'b0;
    sender_active = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // The size register is only written with the block idle; a write also empties the ring.
  task automatic write_size(input logic [brb_pkg::LOG_W-1:0] value);
    drain_results();
    size_log2 <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    ring_log2 = 32'(value);
    head_ptr = 0;
    tail_ptr = 0;
  endtask

  task automatic test_directed_ops();
    int k;
    source_idle_on = 1'b1;
    sink_stall_on = 1'b1;
    send_item(brb_pkg::CMD_READ, rand_bytes(), 7'd5);
    send_item(brb_pkg::CMD_WRITE, rand_bytes(), 7'd0);
    // Nine full bursts put more than one maximum read in the ring.
    for (k = 0; k < 9; k++) begin
      if (k == 0)
        send_item(brb_pkg::CMD_WRITE, {brb_pkg::DATA_W{1'b1}},
                  brb_pkg::LEN_W'(brb_pkg::DEF_MAX_WRITE));
      else if (k == 1)
        send_item(brb_pkg::CMD_WRITE, {brb_pkg::DATA_W{1'b0}},
                  brb_pkg::LEN_W'(brb_pkg::DEF_MAX_WRITE));
      else
        send_item(brb_pkg::CMD_WRITE, rand_bytes(), brb_pkg::LEN_W'(brb_pkg::DEF_MAX_WRITE));
    end
    send_item(brb_pkg::CMD_WRITE, rand_bytes(), brb_pkg::LEN_W'(brb_pkg::DEF_MAX_WRITE + 1));
    send_item(brb_pkg::CMD_WRITE, rand_bytes(), 7'd127);
    send_item(brb_pkg::CMD_READ, rand_bytes(), 7'd127);
    send_item(brb_pkg::CMD_READ, rand_bytes(), 7'd0);
    send_item(CMD_UNUSED, rand_bytes(), 7'd3);
    send_item(brb_pkg::CMD_CLEAR, rand_bytes(), 7'd0);
    send_item(brb_pkg::CMD_READ, rand_bytes(), 7'd10);
  endtask

  task automatic test_size_extremes();
    // A ring of one slot holds nothing.
    write_size(4'd0);
    send_item(brb_pkg::CMD_WRITE, rand_bytes(), 7'd1);
    send_item(brb_pkg::CMD_READ, rand_bytes(), 7'd3);
    // Sizes above the memory depth fall back to the full ring.
    write_size(4'd15);
    send_item(brb_pkg::CMD_WRITE, rand_bytes(), brb_pkg::LEN_W'(brb_pkg::DEF_MAX_WRITE));
    send_item(brb_pkg::CMD_READ, rand_bytes(), 7'd100);
    write_size(4'd1);
    send_item(brb_pkg::CMD_WRITE, rand_bytes(), 7'd1);
    send_item(brb_pkg::CMD_WRITE, rand_bytes(), 7'd1);
    send_item(brb_pkg::CMD_READ, rand_bytes(), 7'd2);
    write_size(4'd3);
    send_item(brb_pkg::CMD_WRITE, rand_bytes(), 7'd7);
    send_item(brb_pkg::CMD_WRITE, rand_bytes(), 7'd1);
    send_item(brb_pkg::CMD_READ, rand_bytes(), 7'd64);
  endtask

  task automatic run_random_phase(input logic [brb_pkg::LOG_W-1:0] lg, input int count,
                                  input int write_pct, input bit idling,
                                  input bit pause_midway);
    int k, pick, len_pick;
    logic [brb_pkg::LEN_W-1:0] len;
    write_size(lg);
    source_idle_on = idling;
    sink_stall_on = idling;
    for (k = 0; k < count; k++) begin
      if (pause_midway && k == count / 2) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < write_pct) begin
        len_pick = $urandom_range(0, 11);
        if (len_pick == 0) len = '0;
        else if (len_pick == 1)
          len = brb_pkg::LEN_W'($urandom_range(brb_pkg::DEF_MAX_WRITE + 1, 127));
        else len = brb_pkg::LEN_W'($urandom_range(1, brb_pkg::DEF_MAX_WRITE));
        send_item(brb_pkg::CMD_WRITE, rand_bytes(), len);
      end else if (pick < 94) begin
        len_pick = $urandom_range(0, 9);
        if (len_pick == 0) len = '0;
        else if (len_pick == 1)
          len = brb_pkg::LEN_W'($urandom_range(brb_pkg::DEF_MAX_READ + 1, 127));
        else if (len_pick == 2)
          len = brb_pkg::LEN_W'($urandom_range(17, brb_pkg::DEF_MAX_READ));
        else len = brb_pkg::LEN_W'($urandom_range(1, 16));
        send_item(brb_pkg::CMD_READ, rand_bytes(), len);
      end else if (pick < 97) begin
        send_item(brb_pkg::CMD_CLEAR, rand_bytes(), brb_pkg::LEN_W'($urandom_range(0, 127)));
      end else begin
        send_item(CMD_UNUSED, rand_bytes(), brb_pkg::LEN_W'($urandom_range(0, 127)));
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(4'd4, 30, 55, 1'b1, 1'b0);
    run_random_phase(4'd10, 30, 75, 1'b1, 1'b1);
    run_random_phase(4'd3, 30, 50, 1'b1, 1'b0);
    run_random_phase(4'd1, 30, 50, 1'b1, 1'b0);
    run_random_phase(4'd15, 30, 65, 1'b1, 1'b0);
    run_random_phase(4'd5, 30, 55, 1'b0, 1'b0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_ops();
    test_size_extremes();
    test_random_traffic();
    drain_results();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
